// ===== rtl/wats_pkg.sv =====
// wats_pkg: shared constants, types and the wall tile table for the wall autotile selector.
// No dependencies; every rtl file refers to it by scoped names.
package wats_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // register field and counter widths
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 4);
   localparam int X_W       = 8;
   localparam int Y_W       = 8;
   localparam int TILE_W    = 6;

   localparam int GRID_WIDTH_RESET  = 64;
   localparam int GRID_HEIGHT_RESET = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   // 5x5 neighborhood, four line delays feed its upper rows
   localparam int WIN       = 5;
   localparam int NUM_LINES = WIN - 1;

   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [TILE_W-1:0] TILE_VOID  = 6'd55;
   localparam logic [TILE_W-1:0] TILE_FLOOR = 6'd7;

   // orthogonal neighbor bits of the wall mask
   localparam logic [3:0] DIR_N = 4'd1;
   localparam logic [3:0] DIR_W = 4'd2;
   localparam logic [3:0] DIR_E = 4'd4;
   localparam logic [3:0] DIR_S = 4'd8;

   localparam logic [TILE_W-1:0] WALL_TABLE [16] = '{
      6'd20, 6'd50, 6'd17, 6'd51, 6'd18, 6'd48, 6'd2,  6'd49,
      6'd33, 6'd32, 6'd4,  6'd19, 6'd0,  6'd16, 6'd34, 6'd1
   };

   // win[k][j]: bit seen k rows and j cells before the newest one
   typedef logic [WIN-1:0]          win_row_type;
   typedef win_row_type [WIN-1:0]   window_type;

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic           last;
      logic [WIN-1:0] x_ok;   // column offsets -2..+2 lie inside the grid
      logic [WIN-1:0] y_ok;   // row offsets -2..+2 lie inside the grid
   } meta_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile;
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic              last;
   } result_type;

endpackage

// ===== rtl/wall_autotile_selector_core.sv =====
// wall_autotile_selector_core: top level of the wall autotile selector.
// Depends on wats_pkg, wats_window, wats_tile_pick and wats_out_fifo.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+------------------------------
//   req     | req_valid / req_ready / req_cell_is_wall| one raster cell item
//   rsp     | rsp_valid / rsp_ready / rsp_tile_index, | one tile item
//           | rsp_out_x, rsp_out_y, rsp_last_of_frame |
//   csr     | csr_wr_en / csr_index / csr_wdata       | grid_width, grid_height
//
// Cycles: one req item per clock sustained while req_ready holds. A tile leaves on rsp once
//   the req item that releases it has passed the tile stage, then the output queue head.
// Reset: synchronous, clears counters, valid flags and the queue; the cell history
//   lines are not cleared and need no clearing pass.
// Stalls: a three-entry output queue absorbs rsp back-pressure; req_ready drops only
//   when the queue plus the tile stage could not take another item.
module wall_autotile_selector_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cell_is_wall,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wats_pkg::TILE_W-1:0]       rsp_tile_index,
   output logic [wats_pkg::X_W-1:0]          rsp_out_x,
   output logic [wats_pkg::Y_W-1:0]          rsp_out_y,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_wr_en,
   input  logic [wats_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wats_pkg::CFG_W-1:0]        csr_wdata
);

   // grid size, already clamped to 1..max
   logic [wats_pkg::CFG_W-1:0]  width_ff, width_in;
   logic [wats_pkg::CFG_W-1:0]  height_ff, height_in;

   // raster position of the next req item
   logic [wats_pkg::COL_W-1:0]  col_ff, col_in;
   logic [wats_pkg::ROW_W-1:0]  row_ff, row_in;

   // position of the next tile to emit
   logic [wats_pkg::X_W-1:0]    ox_ff, ox_in;
   logic [wats_pkg::Y_W-1:0]    oy_ff, oy_in;

   // tile stage
   logic                        s1_valid_ff, s1_valid_in;
   wats_pkg::meta_type          s1_meta_ff, s1_meta_in;

   logic                        accept;
   logic                        emit;
   logic                        frame_end;
   logic                        push_bit;
   wats_pkg::meta_type          meta;
   wats_pkg::window_type        window;
   logic [wats_pkg::TILE_W-1:0] tile;
   wats_pkg::result_type        result;
   wats_pkg::result_type        head;
   logic [wats_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic                        rsp_pop;

   function automatic logic [wats_pkg::CFG_W-1:0] clamp_dim(
      input logic [wats_pkg::CFG_W-1:0] v,
      input logic [wats_pkg::CFG_W-1:0] lim);
      if (v == '0) return wats_pkg::CFG_W'(1);
      if (v > lim) return lim;
      return v;
   endfunction

   assign accept  = req_valid & req_ready;
   assign rsp_pop = rsp_valid & rsp_ready;

   // Room for this item and the one already in the tile stage.
   assign req_ready = ({1'b0, fifo_count} + (wats_pkg::FIFO_CNT_W + 1)'(s1_valid_ff))
                      < (wats_pkg::FIFO_CNT_W + 1)'(wats_pkg::FIFO_DEPTH);

   // Tiles lag the input by two rows plus two cells: n >= 2w+2 with n = row*w + col.
   // Row 3 reaches it for any width above one; row 2 only from the third column on.
   assign emit = (row_ff >= wats_pkg::ROW_W'(4))
              || (row_ff == wats_pkg::ROW_W'(3) && width_ff != wats_pkg::CFG_W'(1))
              || (row_ff == wats_pkg::ROW_W'(2) && col_ff >= wats_pkg::COL_W'(2));

   assign frame_end = (wats_pkg::CFG_W'(ox_ff) == width_ff - wats_pkg::CFG_W'(1))
                   && (wats_pkg::CFG_W'(oy_ff) >= height_ff - wats_pkg::CFG_W'(1));

   // Padding rows below the grid read as floor.
   assign push_bit = req_cell_is_wall & (row_ff < wats_pkg::ROW_W'(height_ff));

   // Which neighbor offsets fall inside the grid for the tile being emitted.
   always_comb begin
      meta.x       = ox_ff;
      meta.y       = oy_ff;
      meta.last    = frame_end;
      meta.x_ok[0] = (ox_ff >= wats_pkg::X_W'(2));
      meta.x_ok[1] = (ox_ff != '0);
      meta.x_ok[2] = 1'b1;
      meta.x_ok[3] = (wats_pkg::CFG_W'(ox_ff) + wats_pkg::CFG_W'(1)) < width_ff;
      meta.x_ok[4] = (wats_pkg::CFG_W'(ox_ff) + wats_pkg::CFG_W'(2)) < width_ff;
      meta.y_ok[0] = (oy_ff >= wats_pkg::Y_W'(2));
      meta.y_ok[1] = (oy_ff != '0);
      meta.y_ok[2] = 1'b1;
      meta.y_ok[3] = (wats_pkg::CFG_W'(oy_ff) + wats_pkg::CFG_W'(1)) < height_ff;
      meta.y_ok[4] = (wats_pkg::CFG_W'(oy_ff) + wats_pkg::CFG_W'(2)) < height_ff;
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      s1_valid_in = accept & emit;
      s1_meta_in  = accept ? meta : s1_meta_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            wats_pkg::CSR_GRID_WIDTH:
               width_in = clamp_dim(csr_wdata, wats_pkg::CFG_W'(wats_pkg::MAX_WIDTH));
            wats_pkg::CSR_GRID_HEIGHT:
               height_in = clamp_dim(csr_wdata, wats_pkg::CFG_W'(wats_pkg::MAX_HEIGHT));
            default: ;
         endcase
         // any write restarts the frame
         col_in = '0;
         row_in = '0;
         ox_in  = '0;
         oy_in  = '0;
      end else if (accept) begin
         if (emit && frame_end) begin
            col_in = '0;
            row_in = '0;
            ox_in  = '0;
            oy_in  = '0;
         end else begin
            if (wats_pkg::CFG_W'(col_ff) + wats_pkg::CFG_W'(1) >= width_ff) begin
               col_in = '0;
               row_in = row_ff + wats_pkg::ROW_W'(1);
            end else begin
               col_in = col_ff + wats_pkg::COL_W'(1);
            end
            if (emit) begin
               if (wats_pkg::CFG_W'(ox_ff) + wats_pkg::CFG_W'(1) >= width_ff) begin
                  ox_in = '0;
                  oy_in = oy_ff + wats_pkg::Y_W'(1);
               end else begin
                  ox_in = ox_ff + wats_pkg::X_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= wats_pkg::CFG_W'(wats_pkg::GRID_WIDTH_RESET);
         height_ff   <= wats_pkg::CFG_W'(wats_pkg::GRID_HEIGHT_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         ox_ff       <= '0;
         oy_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         ox_ff       <= ox_in;
         oy_ff       <= oy_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_meta_ff <= s1_meta_in;
   end

   // History shifts once per accepted item; the window is read the cycle after.
   wats_window u_window (
      .clock     (clock),
      .win_shift (accept),
      .win_bit   (push_bit),
      .win_width (width_ff),
      .win_cells (window)
   );

   wats_tile_pick u_tile_pick (
      .pick_window (window),
      .pick_meta   (s1_meta_ff),
      .pick_tile   (tile)
   );

   always_comb begin
      result.tile = tile;
      result.x    = s1_meta_ff.x;
      result.y    = s1_meta_ff.y;
      result.last = s1_meta_ff.last;
   end

   wats_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .fifo_push  (s1_valid_ff),
      .fifo_wdata (result),
      .fifo_pop   (rsp_pop),
      .fifo_valid (rsp_valid),
      .fifo_rdata (head),
      .fifo_count (fifo_count)
   );

   assign rsp_tile_index    = head.tile;
   assign rsp_out_x         = head.x;
   assign rsp_out_y         = head.y;
   assign rsp_last_of_frame = head.last;

endmodule

// ===== rtl/wats_line.sv =====
// wats_line: one line delay built as a chain of one-bit cells.
// Depends on wats_pkg. The item enters at the cell picked by line_enter and leaves at the far end.
module wats_line (
   input  logic                           clock,
   input  logic                           line_shift,
   input  logic                           line_in,
   input  logic [wats_pkg::MAX_WIDTH-1:0] line_enter,
   output logic                           line_out
);

   logic [wats_pkg::MAX_WIDTH-1:0] cell_ff;
   logic [wats_pkg::MAX_WIDTH-1:0] cell_in;

   always_comb begin
      cell_in[0] = line_enter[0] ? line_in : cell_ff[0];
      for (int i = 1; i < wats_pkg::MAX_WIDTH; i++) begin
         cell_in[i] = line_enter[i] ? line_in : cell_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (line_shift) begin
         cell_ff <= cell_in;
      end
   end

   assign line_out = cell_ff[wats_pkg::MAX_WIDTH-1];

endmodule

// ===== rtl/wats_window.sv =====
// wats_window: cell history as four chained line delays plus the 5x5 neighborhood registers.
// Depends on wats_pkg and wats_line.
module wats_window (
   input  logic                       clock,
   input  logic                       win_shift,
   input  logic                       win_bit,
   input  logic [wats_pkg::CFG_W-1:0] win_width,
   output wats_pkg::window_type       win_cells
);

   logic [wats_pkg::MAX_WIDTH-1:0] enter;
   logic [wats_pkg::NUM_LINES-1:0] line_in;
   logic [wats_pkg::NUM_LINES-1:0] line_out;
   wats_pkg::window_type           win_ff;
   wats_pkg::window_type           win_in;

   // line length equals the row width: enter at cell MAX_WIDTH - width
   always_comb begin
      for (int i = 0; i < wats_pkg::MAX_WIDTH; i++) begin
         enter[i] = (win_width == wats_pkg::CFG_W'(wats_pkg::MAX_WIDTH - i));
      end
   end

   always_comb begin
      line_in[0] = win_bit;
      for (int k = 1; k < wats_pkg::NUM_LINES; k++) begin
         line_in[k] = line_out[k-1];
      end
   end

   for (genvar k = 0; k < wats_pkg::NUM_LINES; k++) begin : g_line
      wats_line u_line (
         .clock      (clock),
         .line_shift (win_shift),
         .line_in    (line_in[k]),
         .line_enter (enter),
         .line_out   (line_out[k])
      );
   end

   always_comb begin
      win_in[0] = {win_ff[0][wats_pkg::WIN-2:0], win_bit};
      for (int k = 1; k < wats_pkg::WIN; k++) begin
         win_in[k] = {win_ff[k][wats_pkg::WIN-2:0], line_out[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (win_shift) begin
         win_ff <= win_in;
      end
   end

   assign win_cells = win_ff;

endmodule

// ===== rtl/wats_tile_pick.sv =====
// wats_tile_pick: picks void, floor or wall tile from the 5x5 neighborhood.
// Depends on wats_pkg.
module wats_tile_pick (
   input  wats_pkg::window_type            pick_window,
   input  wats_pkg::meta_type              pick_meta,
   output logic [wats_pkg::TILE_W-1:0]     pick_tile
);

   localparam int C = 2;   // center index

   localparam logic [3:0] MASK_W_E_S = wats_pkg::DIR_W | wats_pkg::DIR_E | wats_pkg::DIR_S;
   localparam logic [3:0] MASK_N_W_E = wats_pkg::DIR_N | wats_pkg::DIR_W | wats_pkg::DIR_E;
   localparam logic [3:0] MASK_N_W_S = wats_pkg::DIR_N | wats_pkg::DIR_W | wats_pkg::DIR_S;
   localparam logic [3:0] MASK_N_E_S = wats_pkg::DIR_N | wats_pkg::DIR_E | wats_pkg::DIR_S;

   wats_pkg::window_type grid;   // grid[row][col], offsets -2..+2 map to 0..4
   logic                 void_c, void_w, void_e, void_n, void_s;
   logic [3:0]           mask;
   logic [3:0]           mask_adj;

   function automatic logic void_at(input wats_pkg::window_type g, input int cy, input int cx);
      return g[cy-1][cx-1] & g[cy-1][cx+1] & g[cy+1][cx-1] & g[cy+1][cx+1];
   endfunction

   always_comb begin
      for (int r = 0; r < wats_pkg::WIN; r++) begin
         for (int c = 0; c < wats_pkg::WIN; c++) begin
            grid[r][c] = pick_window[wats_pkg::WIN-1-r][wats_pkg::WIN-1-c]
                         & pick_meta.x_ok[c] & pick_meta.y_ok[r];
         end
      end
   end

   always_comb begin
      void_c = void_at(grid, C, C);
      void_w = void_at(grid, C, C-1);
      void_e = void_at(grid, C, C+1);
      void_n = void_at(grid, C-1, C);
      void_s = void_at(grid, C+1, C);
      mask   = {grid[C+1][C], grid[C][C+1], grid[C][C-1], grid[C-1][C]};

      mask_adj = mask;
      unique case (mask)
         MASK_W_E_S: begin
            if (void_w)      mask_adj = wats_pkg::DIR_E | wats_pkg::DIR_S;
            else if (void_e) mask_adj = wats_pkg::DIR_W | wats_pkg::DIR_S;
            else if (void_s) mask_adj = wats_pkg::DIR_W | wats_pkg::DIR_E;
         end
         MASK_N_W_E: begin
            if (void_n)      mask_adj = wats_pkg::DIR_W | wats_pkg::DIR_E;
            else if (void_w) mask_adj = wats_pkg::DIR_N | wats_pkg::DIR_E;
            else if (void_e) mask_adj = wats_pkg::DIR_N | wats_pkg::DIR_W;
         end
         MASK_N_W_S: begin
            if (void_n)      mask_adj = wats_pkg::DIR_W | wats_pkg::DIR_S;
            else if (void_w) mask_adj = wats_pkg::DIR_N | wats_pkg::DIR_S;
            else if (void_s) mask_adj = wats_pkg::DIR_N | wats_pkg::DIR_W;
         end
         MASK_N_E_S: begin
            if (void_s)      mask_adj = wats_pkg::DIR_N | wats_pkg::DIR_E;
            else if (void_e) mask_adj = wats_pkg::DIR_N | wats_pkg::DIR_S;
            else if (void_n) mask_adj = wats_pkg::DIR_E | wats_pkg::DIR_S;
         end
         default: mask_adj = mask;
      endcase

      if (void_c)              pick_tile = wats_pkg::TILE_VOID;
      else if (!grid[C][C])    pick_tile = wats_pkg::TILE_FLOOR;
      else                     pick_tile = wats_pkg::WALL_TABLE[mask_adj];
   end

endmodule

// ===== rtl/wats_out_fifo.sv =====
// wats_out_fifo: small result queue that parts the pipeline from the rsp channel.
// Depends on wats_pkg.
module wats_out_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fifo_push,
   input  wats_pkg::result_type            fifo_wdata,
   input  logic                            fifo_pop,
   output logic                            fifo_valid,
   output wats_pkg::result_type            fifo_rdata,
   output logic [wats_pkg::FIFO_CNT_W-1:0] fifo_count
);

   wats_pkg::result_type                entry_ff [wats_pkg::FIFO_DEPTH];
   logic [wats_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [wats_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [wats_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;

   function automatic logic [wats_pkg::FIFO_PTR_W-1:0] ptr_next(
      input logic [wats_pkg::FIFO_PTR_W-1:0] p);
      if (p == wats_pkg::FIFO_PTR_W'(wats_pkg::FIFO_DEPTH - 1)) return '0;
      return p + wats_pkg::FIFO_PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = fifo_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = fifo_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + wats_pkg::FIFO_CNT_W'(fifo_push)
                           - wats_pkg::FIFO_CNT_W'(fifo_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         entry_ff[wr_ptr_ff] <= fifo_wdata;
      end
   end

   assign fifo_valid = (count_ff != '0);
   assign fifo_rdata = entry_ff[rd_ptr_ff];
   assign fifo_count = count_ff;

endmodule

// ===== rtl/wats_checker.sv =====
// wats_checker: port-level checks on the wall autotile selector, bound to the top level.
// Depends on wats_pkg and wall_autotile_selector_core.
module wats_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [wats_pkg::TILE_W-1:0]       rsp_tile_index,
   input logic [wats_pkg::X_W-1:0]          rsp_out_x,
   input logic [wats_pkg::Y_W-1:0]          rsp_out_y,
   input logic                              rsp_last_of_frame,
   input logic                              csr_wr_en
);

   logic                     rsp_fire;
   logic                     start_ff, start_in;
   logic [wats_pkg::X_W-1:0] px_ff, px_in;
   logic [wats_pkg::Y_W-1:0] py_ff, py_in;

   assign rsp_fire = rsp_valid & rsp_ready;

   // expect the origin after reset, a register write, or a frame's last tile
   always_comb begin
      start_in = start_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      if (csr_wr_en) begin
         start_in = 1'b1;
      end else if (rsp_fire) begin
         start_in = rsp_last_of_frame;
         px_in    = rsp_out_x;
         py_in    = rsp_out_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
      end else begin
         start_ff <= start_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_index)
         && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_last_of_frame))
      else $error("rsp item changed while stalled");

   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && start_ff |-> rsp_out_x == '0 && rsp_out_y == '0)
      else $error("frame does not start at the origin");

   a_raster_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !start_ff |->
         (rsp_out_x == px_ff + wats_pkg::X_W'(1) && rsp_out_y == py_ff)
         || (rsp_out_x == '0
             && {1'b0, rsp_out_y} == {1'b0, py_ff} + (wats_pkg::Y_W + 1)'(1)))
      else $error("tile out of raster order");

   a_tile_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tile_index <= wats_pkg::TILE_W'(51)
         || rsp_tile_index == wats_pkg::TILE_VOID
         || rsp_tile_index == wats_pkg::TILE_FLOOR)
      else $error("tile number outside the tile set");

endmodule

bind wall_autotile_selector_core wats_checker u_wats_checker (.*);

// ===== verif/tb_wall_autotile_selector_core.sv =====
// Self-checking bench for wall_autotile_selector_core: random cell streams in raster order,
// a built-in tile predictor and in-order comparison of every tile item.
// Depends on wats_pkg (register indexes and port widths) and the core itself.
`timescale 1ns / 100ps

module tb_wall_autotile_selector_core;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;     // core emits through the tile stage and the output queue; margin on top
   localparam int TARGET_CELLS  = 550;

   localparam int MAX_W      = wats_pkg::MAX_WIDTH;
   localparam int MAX_H      = wats_pkg::MAX_HEIGHT;
   localparam int HIST_DEPTH = 4 * MAX_W + 5;

   // tile numbers and the wall mask layout
   localparam logic [5:0] VOID_TILE  = 6'd55;
   localparam logic [5:0] FLOOR_TILE = 6'd7;
   localparam logic [3:0] MASK_N = 4'd1;
   localparam logic [3:0] MASK_W = 4'd2;
   localparam logic [3:0] MASK_E = 4'd4;
   localparam logic [3:0] MASK_S = 4'd8;
   localparam logic [5:0] WALL_TILES [16] = '{
      6'd20, 6'd50, 6'd17, 6'd51, 6'd18, 6'd48, 6'd2,  6'd49,
      6'd33, 6'd32, 6'd4,  6'd19, 6'd0,  6'd16, 6'd34, 6'd1
   };

   typedef struct {
      logic [5:0] tile;
      logic [7:0] x;
      logic [7:0] y;
      logic       last;
   } tile_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic       req_cell_is_wall = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [wats_pkg::TILE_W-1:0]    rsp_tile_index;
   logic [wats_pkg::X_W-1:0]       rsp_out_x;
   logic [wats_pkg::Y_W-1:0]       rsp_out_y;
   logic                           rsp_last_of_frame;
   logic                           csr_wr_en = 1'b0;
   logic [wats_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wats_pkg::CFG_W-1:0]     csr_wdata = '0;

   wall_autotile_selector_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cell_is_wall  (req_cell_is_wall),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tile_index    (rsp_tile_index),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Tile predictor: mirrors the core's cell history, raster counters
   // and geometry registers; one call per accepted cell item.
   // ------------------------------------------------------------------
   bit         cell_hist [HIST_DEPTH];
   int         hist_head = 0;
   int         in_col    = 0;
   int         in_row    = 0;
   logic [8:0] cfg_width  = 9'd64;
   logic [8:0] cfg_height = 9'd64;

   // geometry and position of the cell whose tile is being chosen
   int win_x, win_y, win_w, win_h;

   tile_item_type tile_expect_q [$];
   bit            cell_queue [$];
   int            mismatch_count = 0;
   int            cells_sent     = 0;

   // zero counts as one, anything past the maximum saturates
   function automatic int clamp_dim(logic [8:0] v, int max_v);
      if (v == 0) return 1;
      if (v > max_v) return max_v;
      return int'(v);
   endfunction

   // Wall bit at an offset from the current cell; off-grid reads as floor.
   function automatic bit hist_wall(int dx, int dy);
      int px, py, age;
      px = win_x + dx;
      py = win_y + dy;
      if (px < 0 || py < 0 || px >= win_w || py >= win_h) return 1'b0;
      age = 2 * win_w + 2 - dy * win_w - dx;
      if (age < 0 || age >= HIST_DEPTH) return 1'b0;
      return cell_hist[(hist_head + HIST_DEPTH - age) % HIST_DEPTH];
   endfunction

   // a spot is void when all four of its diagonals are walls
   function automatic bit diag_void(int dx, int dy);
      return hist_wall(dx - 1, dy - 1) && hist_wall(dx + 1, dy - 1) &&
             hist_wall(dx - 1, dy + 1) && hist_wall(dx + 1, dy + 1);
   endfunction

   function automatic logic [5:0] choose_tile();
      logic [3:0] mask;
      mask = '0;
      if (diag_void(0, 0)) return VOID_TILE;
      if (!hist_wall(0, 0)) return FLOOR_TILE;
      if (hist_wall(0, -1)) mask |= MASK_N;
      if (hist_wall(-1, 0)) mask |= MASK_W;
      if (hist_wall(1, 0))  mask |= MASK_E;
      if (hist_wall(0, 1))  mask |= MASK_S;
      // three-sided walls bend away from an adjacent void spot
      if (mask == (MASK_W | MASK_E | MASK_S)) begin
         if (diag_void(-1, 0))     mask = MASK_E | MASK_S;
         else if (diag_void(1, 0)) mask = MASK_W | MASK_S;
         else if (diag_void(0, 1)) mask = MASK_W | MASK_E;
      end else if (mask == (MASK_N | MASK_W | MASK_E)) begin
         if (diag_void(0, -1))     mask = MASK_W | MASK_E;
         else if (diag_void(-1, 0)) mask = MASK_N | MASK_E;
         else if (diag_void(1, 0)) mask = MASK_N | MASK_W;
      end else if (mask == (MASK_N | MASK_W | MASK_S)) begin
         if (diag_void(0, -1))     mask = MASK_W | MASK_S;
         else if (diag_void(-1, 0)) mask = MASK_N | MASK_S;
         else if (diag_void(0, 1)) mask = MASK_N | MASK_W;
      end else if (mask == (MASK_N | MASK_E | MASK_S)) begin
         if (diag_void(0, 1))      mask = MASK_N | MASK_E;
         else if (diag_void(1, 0)) mask = MASK_N | MASK_S;
         else if (diag_void(0, -1)) mask = MASK_E | MASK_S;
      end
      return WALL_TILES[mask];
   endfunction

   // Shift one cell into the history; queue the tile that it releases.
   function automatic void advance_raster(bit wall);
      int            w, h, lag, n, c;
      bit            frame_done;
      tile_item_type due;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      lag = 2 * w + 2;
      frame_done = 1'b0;
      hist_head = (hist_head + 1) % HIST_DEPTH;
      cell_hist[hist_head] = (in_row < h) ? wall : 1'b0;   // padding is floor
      n = in_row * w + in_col;
      if (n >= lag) begin
         c = n - lag;
         win_w = w;
         win_h = h;
         win_x = c % w;
         win_y = c / w;
         frame_done = (win_x == w - 1) && (win_y >= h - 1);
         due.tile = choose_tile();
         due.x    = win_x[7:0];
         due.y    = win_y[7:0];
         due.last = frame_done;
         tile_expect_q.push_back(due);
      end
      if (frame_done) begin
         in_col = 0;
         in_row = 0;
      end else begin
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Idle pattern: mostly short gaps, a few long ones, and now and then
   // a calm run with no gaps at all.
   // ------------------------------------------------------------------
   function automatic int draw_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // ------------------------------------------------------------------
   // Cell driver: pops the pending queue; valid holds until accepted.
   // The predictor runs on the item accepted at this edge.
   // ------------------------------------------------------------------
   int req_gap  = 0;
   int req_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready)
            advance_raster(req_cell_is_wall);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (cell_queue.size() != 0) begin
               req_valid        <= 1'b1;
               req_cell_is_wall <= cell_queue.pop_front();
               req_gap          <= draw_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tile monitor: random back-pressure, in-order field compare.
   // ------------------------------------------------------------------
   int            rsp_hold = 0;
   int            rsp_calm = 0;
   tile_item_type got_tile;

   function automatic void check_field(string name, int want, int seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tile_expect_q.size() == 0) begin
               $error("unexpected tile item: tile %0d at (%0d,%0d)",
                      rsp_tile_index, rsp_out_x, rsp_out_y);
               mismatch_count++;
            end else begin
               got_tile = tile_expect_q.pop_front();
               check_field("tile_index", got_tile.tile, rsp_tile_index);
               check_field("out_x", got_tile.x, rsp_out_x);
               check_field("out_y", got_tile.y, rsp_out_y);
               check_field("last_of_frame", got_tile.last, rsp_last_of_frame);
            end
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold  <= ($urandom_range(0, 3) == 0) ? draw_gap(rsp_calm) : 0;
         end
      end
   end

   // watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Wait, sampled between edges, until every cell has gone in and every
   // tile has come out, then give the pipeline time to empty.
   task automatic drain();
      while (cell_queue.size() != 0 || req_valid || tile_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; the predictor restarts its frame the same way.
   task automatic write_csr(logic [wats_pkg::CSR_IDX_W-1:0] idx,
                            logic [wats_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == wats_pkg::CSR_GRID_WIDTH) cfg_width = value;
      else cfg_height = value;
      in_col = 0;
      in_row = 0;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_grid(int w, int h);
      write_csr(wats_pkg::CSR_GRID_WIDTH, w[8:0]);
      write_csr(wats_pkg::CSR_GRID_HEIGHT, h[8:0]);
   endtask

   task automatic queue_fixed(int count, bit wall);
      int i;
      for (i = 0; i < count; i++) cell_queue.push_back(wall);
      cells_sent += count;
   endtask

   // Whole frames (cells plus trailing padding) of random walls at the
   // given percentage; optionally the last frame stops part way.
   task automatic queue_frames(int frames, int density, bit cut_short);
      int w, h, span, stop, f, i;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      span = w * h + 2 * w + 2;
      for (f = 0; f < frames; f++) begin
         stop = span;
         if (cut_short && f == frames - 1) stop = $urandom_range(1, span - 1);
         for (i = 0; i < stop; i++)
            cell_queue.push_back($urandom_range(0, 99) < density);
         cells_sent += stop;
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   int roll, new_w, new_h;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-cell grid, wall with walls in its padding
      // (padding must read as floor, so the tile is the isolated wall).
      set_grid(1, 1);
      @(negedge clock);
      queue_fixed(5, 1'b1);
      drain();

      // Directed: 3x3 all walls, padding bits set; center is void, the
      // edges and corners exercise the mask table.
      set_grid(3, 3);
      @(negedge clock);
      queue_fixed(17, 1'b1);
      drain();

      // Out-of-range writes: zero width reads as one, a height past the
      // maximum saturates, giving the tallest single column.
      set_grid(0, 300);
      @(negedge clock);
      queue_frames(1, 80, 1'b0);
      drain();

      // Random phases: mostly small grids, sometimes one register only,
      // density swept so void spots and mask overrides both show up.
      while (cells_sent < TARGET_CELLS) begin
         roll = $urandom_range(0, 99);
         new_w = (roll < 70) ? $urandom_range(1, 8) :
                 (roll < 90) ? $urandom_range(9, 24) : $urandom_range(0, 3);
         roll = $urandom_range(0, 99);
         new_h = (roll < 80) ? $urandom_range(1, 10) : $urandom_range(0, 3);
         roll = $urandom_range(0, 3);
         if (roll == 0) write_csr(wats_pkg::CSR_GRID_WIDTH, new_w[8:0]);
         else if (roll == 1) write_csr(wats_pkg::CSR_GRID_HEIGHT, new_h[8:0]);
         else set_grid(new_w, new_h);
         @(negedge clock);
         queue_frames($urandom_range(1, 2), $urandom_range(30, 95),
                      $urandom_range(0, 4) == 0);
         drain();
      end

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
